/* rtl/vrsa_pkg.sv */
// ============================================================================
// vrsa_pkg
// Shared types and constants of the virtual region slot allocator.
// ============================================================================
package vrsa_pkg;

    // Configuration port
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;
    localparam int SIZE_W = 23;

    localparam logic [2:0] REG_TOP   = 3'd0;
    localparam logic [2:0] REG_START = 3'd1;
    localparam logic [2:0] REG_BIG   = 3'd2;
    localparam logic [2:0] REG_MID   = 3'd3;
    localparam logic [2:0] REG_SMALL = 3'd4;

    localparam logic [31:0]       TOP_RESET   = 32'h4040_0000;
    localparam logic [31:0]       START_RESET = 32'h401B_0000;
    localparam logic [SIZE_W-1:0] BIG_RESET   = 23'h05_0000;
    localparam logic [SIZE_W-1:0] MID_RESET   = 23'h03_0000;
    localparam logic [SIZE_W-1:0] SMALL_RESET = 23'h02_0000;

    // Operation kinds
    localparam logic [1:0] KIND_REQUEST = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_LOOKUP  = 2'd2;
    localparam logic [1:0] KIND_NEXT    = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_FREE  = 3'd1;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd2;
    localparam logic [2:0] ST_INVALID  = 3'd3;
    localparam logic [2:0] ST_END      = 3'd4;

    // Slot size groups
    localparam logic [1:0] GRP_BIG   = 2'd0;
    localparam logic [1:0] GRP_MID   = 2'd1;
    localparam logic [1:0] GRP_SMALL = 2'd2;

    // Per-group slot counter (four bits wide, so it counts up to fifteen slots)
    localparam int GCNT_W = 4;

    typedef struct packed {
        logic [31:0]       top_address;
        logic [31:0]       start_address;
        logic [SIZE_W-1:0] big_slot_size;
        logic [SIZE_W-1:0] mid_slot_size;
        logic [SIZE_W-1:0] small_slot_size;
    } cfg_t;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] length;
        logic [31:0] used;
    } slot_entry_t;

endpackage

/* rtl/vrsa_if.sv */
// ============================================================================
// vrsa_if
// Valid/ready channel interfaces for allocator operations and results.
// ============================================================================
interface vrsa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] request_size;
    logic [31:0] address;
    logic [3:0]  slot_number;

    modport source (output valid, output kind, output request_size, output address,
                    output slot_number, input ready);
    modport sink   (input valid, input kind, input request_size, input address,
                    input slot_number, output ready);
endinterface

interface vrsa_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] result_address;
    logic [3:0]  result_slot;

    modport source (output valid, output status, output result_address,
                    output result_slot, input ready);
    modport sink   (input valid, input status, input result_address,
                    input result_slot, output ready);
endinterface

/* rtl/vrsa_cfg.sv */
// ============================================================================
// vrsa_cfg
// APB-style register file holding the layout configuration.
// ============================================================================
module vrsa_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vrsa_pkg::CFG_AW-1:0] paddr,
    input  logic [vrsa_pkg::CFG_DW-1:0] pwdata,
    output logic [vrsa_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    output vrsa_pkg::cfg_t              cfg
);
    import vrsa_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[CFG_AW-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.top_address     <= TOP_RESET;
            cfg_reg.start_address   <= START_RESET;
            cfg_reg.big_slot_size   <= BIG_RESET;
            cfg_reg.mid_slot_size   <= MID_RESET;
            cfg_reg.small_slot_size <= SMALL_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_TOP:   cfg_reg.top_address     <= pwdata;
                REG_START: cfg_reg.start_address   <= pwdata;
                REG_BIG:   cfg_reg.big_slot_size   <= pwdata[SIZE_W-1:0];
                REG_MID:   cfg_reg.mid_slot_size   <= pwdata[SIZE_W-1:0];
                REG_SMALL: cfg_reg.small_slot_size <= pwdata[SIZE_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TOP:   prdata = cfg_reg.top_address;
            REG_START: prdata = cfg_reg.start_address;
            REG_BIG:   prdata = {{(CFG_DW-SIZE_W){1'b0}}, cfg_reg.big_slot_size};
            REG_MID:   prdata = {{(CFG_DW-SIZE_W){1'b0}}, cfg_reg.mid_slot_size};
            REG_SMALL: prdata = {{(CFG_DW-SIZE_W){1'b0}}, cfg_reg.small_slot_size};
            default:   prdata = '0;
        endcase
    end

endmodule

/* rtl/vrsa_slot_mem.sv */
// ============================================================================
// vrsa_slot_mem
// Slot table: one write port, one read port with registered read data.
// ============================================================================
module vrsa_slot_mem #(
    parameter int DEPTH = 10,
    parameter int IDXW  = 4
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [IDXW-1:0]       wr_addr,
    input  vrsa_pkg::slot_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [IDXW-1:0]       rd_addr,
    output vrsa_pkg::slot_entry_t rd_data
);
    import vrsa_pkg::*;

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

/* rtl/vrsa_ctrl.sv */
// ============================================================================
// vrsa_ctrl
// Operation sequencer: layout build, slot table scan and next-page step.
// ============================================================================
module vrsa_ctrl #(
    parameter int BIG_SLOTS   = 2,
    parameter int MID_SLOTS   = 3,
    parameter int SMALL_SLOTS = 5,
    parameter int PAGE_BYTES  = 65536,
    parameter int TOTAL       = 10,
    parameter int IDXW        = 4,
    parameter int CNTW        = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  vrsa_pkg::cfg_t        cfg,
    vrsa_in_if.sink               req,
    vrsa_out_if.source            rsp,
    output logic                  mem_wr_en,
    output logic [IDXW-1:0]       mem_wr_addr,
    output vrsa_pkg::slot_entry_t mem_wr_data,
    output logic                  mem_rd_en,
    output logic [IDXW-1:0]       mem_rd_addr,
    input  vrsa_pkg::slot_entry_t mem_rd_data
);
    import vrsa_pkg::*;

    localparam logic [31:0] PAGE32    = 32'(PAGE_BYTES);
    localparam logic [31:0] PAGE_MASK = ~(PAGE32 - 32'd1);
    localparam logic [GCNT_W-1:0] N_BIG   = GCNT_W'(BIG_SLOTS);
    localparam logic [GCNT_W-1:0] N_MID   = GCNT_W'(MID_SLOTS);
    localparam logic [GCNT_W-1:0] N_SMALL = GCNT_W'(SMALL_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_PLACE,
        S_SCAN,
        S_NRD,
        S_NCHK,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [1:0]              kind_reg, kind_next;
    logic [31:0]             size_reg, size_next;
    logic [31:0]             addr_reg, addr_next;
    logic [3:0]              sn_reg, sn_next;
    logic [31:0]             walk_reg, walk_next;
    logic [31:0]             lowest_reg, lowest_next;
    logic [1:0]              grp_reg, grp_next;
    logic [GCNT_W-1:0]       k_reg, k_next;
    logic [2:0][GCNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNTW-1:0]         count_reg, count_next;
    logic                    built_reg, built_next;
    logic [TOTAL-1:0]        taken_reg, taken_next;
    logic [CNTW-1:0]         rd_idx_reg, rd_idx_next;
    logic                    chk_valid_reg, chk_valid_next;
    logic [IDXW-1:0]         chk_idx_reg, chk_idx_next;
    logic [2:0]              res_status_reg, res_status_next;
    logic [31:0]             res_addr_reg, res_addr_next;
    logic [3:0]              res_slot_reg, res_slot_next;
    logic                    out_valid_reg, out_valid_next;
    logic [2:0]              out_status_reg, out_status_next;
    logic [31:0]             out_addr_reg, out_addr_next;
    logic [3:0]              out_slot_reg, out_slot_next;

    logic [GCNT_W-1:0] grp_n;
    logic [31:0]       grp_size;
    logic [31:0]       step_addr;
    logic              scan_hit;
    logic [31:0]       span_end;
    logic [31:0]       next_page;
    logic [31:0]       used_end;

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.result_address = out_addr_reg;
    assign rsp.result_slot    = out_slot_reg;

    always_comb
    begin
        case (grp_reg)
            GRP_BIG:
            begin
                grp_n    = N_BIG;
                grp_size = {{(32-SIZE_W){1'b0}}, cfg.big_slot_size};
            end
            GRP_MID:
            begin
                grp_n    = N_MID;
                grp_size = {{(32-SIZE_W){1'b0}}, cfg.mid_slot_size};
            end
            default:
            begin
                grp_n    = N_SMALL;
                grp_size = {{(32-SIZE_W){1'b0}}, cfg.small_slot_size};
            end
        endcase
    end

    assign step_addr = (walk_reg - grp_size) & PAGE_MASK;
    assign span_end  = mem_rd_data.base + mem_rd_data.length;
    assign next_page = addr_reg + PAGE32;
    assign used_end  = mem_rd_data.base + mem_rd_data.used;

    always_comb
    begin
        if (kind_reg == KIND_REQUEST)
        begin
            scan_hit = !taken_reg[chk_idx_reg] && (size_reg <= mem_rd_data.length);
        end
        else
        begin
            scan_hit = taken_reg[chk_idx_reg] && (mem_rd_data.base == addr_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        sn_next         = sn_reg;
        walk_next       = walk_reg;
        lowest_next     = lowest_reg;
        grp_next        = grp_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        count_next      = count_reg;
        built_next      = built_reg;
        taken_next      = taken_reg;
        rd_idx_next     = rd_idx_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_slot_next   = res_slot_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = chk_idx_reg;
        mem_wr_data     = '0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = rd_idx_reg[IDXW-1:0];

        // Result register drains independently of the sequencer
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_slot_next   = out_slot_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next   = req.kind;
                    size_next   = req.request_size;
                    addr_next   = req.address;
                    sn_next     = req.slot_number;
                    rd_idx_next = '0;
                    if (req.kind == KIND_REQUEST && !built_reg)
                    begin
                        walk_next   = cfg.top_address;
                        lowest_next = (cfg.start_address + 32'd1) & PAGE_MASK;
                        grp_next    = GRP_BIG;
                        k_next      = '0;
                        cnt_next    = '0;
                        state_next  = S_STEP;
                    end
                    else if (req.kind == KIND_NEXT)
                    begin
                        res_slot_next = req.slot_number;
                        res_addr_next = '0;
                        if (32'(req.slot_number) >= 32'(count_reg))
                        begin
                            res_status_next = ST_INVALID;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_NRD;
                        end
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_STEP:
            begin
                if (k_reg >= grp_n)
                begin
                    k_next = '0;
                    if (grp_reg == GRP_SMALL)
                    begin
                        count_next = '0;
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        grp_next = grp_reg + 2'd1;
                    end
                end
                else if (step_addr < lowest_reg)
                begin
                    // Stop here: place from the lowest address reached
                    grp_next   = GRP_SMALL;
                    k_next     = '0;
                    count_next = '0;
                    state_next = S_PLACE;
                end
                else
                begin
                    walk_next          = step_addr;
                    cnt_next[grp_reg]  = k_reg + GCNT_W'(1);
                    k_next             = k_reg + GCNT_W'(1);
                end
            end

            S_PLACE:
            begin
                if (k_reg >= cnt_reg[grp_reg])
                begin
                    k_next = '0;
                    if (grp_reg == GRP_BIG)
                    begin
                        built_next = 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        grp_next = grp_reg - 2'd1;
                    end
                end
                else
                begin
                    mem_wr_en          = 1'b1;
                    mem_wr_addr        = count_reg[IDXW-1:0];
                    mem_wr_data.base   = walk_reg;
                    mem_wr_data.length = grp_size;
                    mem_wr_data.used   = '0;
                    walk_next          = walk_reg + grp_size;
                    count_next         = count_reg + CNTW'(1);
                    k_next             = k_reg + GCNT_W'(1);
                end
            end

            S_SCAN:
            begin
                // One read issued per cycle; the entry read last cycle is checked
                if (chk_valid_reg && scan_hit)
                begin
                    res_status_next = ST_OK;
                    res_slot_next   = 4'(chk_idx_reg);
                    res_addr_next   = '0;
                    if (kind_reg == KIND_REQUEST)
                    begin
                        res_addr_next          = mem_rd_data.base;
                        taken_next[chk_idx_reg] = 1'b1;
                        mem_wr_en              = 1'b1;
                        mem_wr_addr            = chk_idx_reg;
                        mem_wr_data.base       = mem_rd_data.base;
                        mem_wr_data.length     = mem_rd_data.length;
                        mem_wr_data.used       = size_reg;
                    end
                    else if (kind_reg == KIND_RELEASE)
                    begin
                        taken_next[chk_idx_reg] = 1'b0;
                    end
                    state_next = S_DONE;
                end
                else if (rd_idx_reg < count_reg)
                begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = rd_idx_reg[IDXW-1:0];
                    chk_valid_next = 1'b1;
                    chk_idx_next   = rd_idx_reg[IDXW-1:0];
                    rd_idx_next    = rd_idx_reg + CNTW'(1);
                end
                else if (!chk_valid_reg || !scan_hit)
                begin
                    res_status_next = (kind_reg == KIND_REQUEST) ? ST_NO_FREE : ST_NOT_ALLOC;
                    res_slot_next   = '0;
                    res_addr_next   = '0;
                    state_next      = S_DONE;
                end
            end

            S_NRD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = IDXW'(sn_reg);
                state_next  = S_NCHK;
            end

            S_NCHK:
            begin
                if (addr_reg < mem_rd_data.base || addr_reg >= span_end ||
                    next_page > span_end)
                begin
                    res_status_next = ST_INVALID;
                end
                else if (next_page >= used_end)
                begin
                    res_status_next = ST_END;
                end
                else
                begin
                    res_status_next = ST_OK;
                    res_addr_next   = next_page;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    out_slot_next   = res_slot_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            built_reg     <= 1'b0;
            taken_reg     <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            grp_reg       <= GRP_BIG;
            k_reg         <= '0;
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            built_reg     <= built_next;
            taken_reg     <= taken_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
            grp_reg       <= grp_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
            rd_idx_reg    <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        sn_reg         <= sn_next;
        walk_reg       <= walk_next;
        lowest_reg     <= lowest_next;
        chk_idx_reg    <= chk_idx_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_slot_reg   <= out_slot_next;
    end

endmodule

/* rtl/virtual_region_slot_allocator.sv */
// ============================================================================
// virtual_region_slot_allocator
// Virtual address slot table with lazy layout build and APB configuration.
// ============================================================================
// One operation is handled at a time. The first slot request builds the
// layout: downward steps through each size group until the group is full
// or the descent stops, then the placement of each slot group by group, all
// through the sequencer. A request, release or lookup then scans the slot
// table memory at one entry per cycle; each entry passes the registered read
// of the table and the check, and the result goes to the result register. A
// next-address step reads the entry of its slot, checks it and registers the
// result. The next operation is taken as soon as the result is in the output
// register, even if it has not yet been transferred.
module virtual_region_slot_allocator #(
    parameter int BIG_SLOTS   = 2,
    parameter int MID_SLOTS   = 3,
    parameter int SMALL_SLOTS = 5,
    parameter int PAGE_BYTES  = 65536
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vrsa_pkg::CFG_AW-1:0] paddr,
    input  logic [vrsa_pkg::CFG_DW-1:0] pwdata,
    output logic [vrsa_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    vrsa_in_if.sink                     req,
    vrsa_out_if.source                  rsp
);
    import vrsa_pkg::*;

    localparam int TOTAL = (BIG_SLOTS + MID_SLOTS + SMALL_SLOTS > 0) ?
                           (BIG_SLOTS + MID_SLOTS + SMALL_SLOTS) : 1;
    localparam int IDXW  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int CNTW  = $clog2(TOTAL + 1);

    cfg_t            cfg;
    logic            mem_wr_en;
    logic [IDXW-1:0] mem_wr_addr;
    slot_entry_t     mem_wr_data;
    logic            mem_rd_en;
    logic [IDXW-1:0] mem_rd_addr;
    slot_entry_t     mem_rd_data;

    vrsa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vrsa_slot_mem #(
        .DEPTH (TOTAL),
        .IDXW  (IDXW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    vrsa_ctrl #(
        .BIG_SLOTS   (BIG_SLOTS),
        .MID_SLOTS   (MID_SLOTS),
        .SMALL_SLOTS (SMALL_SLOTS),
        .PAGE_BYTES  (PAGE_BYTES),
        .TOTAL       (TOTAL),
        .IDXW        (IDXW),
        .CNTW        (CNTW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .req         (req),
        .rsp         (rsp),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

endmodule
